// ----- sv/htbi_pkg.sv -----
// ----------------------------------------------------------------------------
// htbi_pkg
// Shared constants, types and helpers of the HT bit interleaver.
// ----------------------------------------------------------------------------
package htbi_pkg;

    localparam int MAX_BLOCK = 2048;
    localparam int BLK_AW    = $clog2(MAX_BLOCK);
    localparam int STORE_AW  = BLK_AW + 1;
    localparam int DIV_W     = 12;
    localparam int DIV_STEPS = DIV_W;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS   = 3'd0,
        CFG_COLS   = 3'd1,
        CFG_BPSC   = 3'd2,
        CFG_ROT    = 3'd3,
        CFG_STREAM = 3'd4
    } cfg_idx_t;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic       busy;
        logic [5:0] start_row;
        logic [4:0] start_col;
    } rot_info_t;

    function automatic logic [5:0] eff_cols(input logic [5:0] c);
        logic [5:0] r;
        r = c;
        if (c == 6'd0) r = 6'd1;
        else if (c > 6'd32) r = 6'd32;
        return r;
    endfunction

    function automatic logic [6:0] eff_rows(input logic [6:0] c);
        logic [6:0] r;
        r = c;
        if (c == 7'd0) r = 7'd1;
        else if (c > 7'd64) r = 7'd64;
        return r;
    endfunction

    // rotation multiple per stream: 0, 2, 1, 3
    function automatic logic [1:0] stream_mult(input logic [1:0] s);
        logic [1:0] m;
        case (s)
            2'd0:    m = 2'd0;
            2'd1:    m = 2'd2;
            2'd2:    m = 2'd1;
            default: m = 2'd3;
        endcase
        return m;
    endfunction

endpackage

// ----- sv/htbi_rotation.sv -----
// ----------------------------------------------------------------------------
// htbi_rotation
// Works out the frequency rotation start point (row, column) after a
// configuration write, with one shared restoring divider.
// ----------------------------------------------------------------------------
module htbi_rotation import htbi_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [1:0]        stream,
    input  logic [5:0]        rot_step,
    input  logic [3:0]        bpsc,
    input  logic [DIV_W-1:0]  block_len,
    input  logic [5:0]        cols,
    output rot_info_t         info
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_MOD   = 5'b01000,
        ST_SPLIT = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [7:0]       part_reg, part_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [5:0]       row_reg, row_next;
    logic [4:0]       col_reg, col_next;

    logic [DIV_W-1:0] rem_sh, rem_new, quo_new;
    logic             ge;
    logic             last_step;

    assign rem_sh    = {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
    assign ge        = (rem_sh >= div_reg);
    assign rem_new   = ge ? (rem_sh - div_reg) : rem_sh;
    assign quo_new   = {quo_reg[DIV_W-2:0], ge};
    assign last_step = (cnt_reg == 4'(DIV_STEPS - 1));

    always_comb begin
        state_next = state_reg;
        part_next  = part_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        if (start) begin
            state_next = ST_MUL;
        end else begin
            unique case (state_reg)
                ST_IDLE: ;
                ST_MUL: begin
                    part_next  = {6'd0, stream_mult(stream)} * {2'd0, rot_step};
                    state_next = ST_LOAD;
                end
                ST_LOAD: begin
                    quo_next   = {4'd0, part_reg} * {8'd0, bpsc};
                    rem_next   = '0;
                    div_next   = block_len;
                    cnt_next   = '0;
                    state_next = ST_MOD;
                end
                ST_MOD: begin
                    rem_next = rem_new;
                    quo_next = quo_new;
                    cnt_next = cnt_reg + 4'd1;
                    if (last_step) begin
                        quo_next   = rem_new;
                        rem_next   = '0;
                        div_next   = DIV_W'(cols);
                        cnt_next   = '0;
                        state_next = ST_SPLIT;
                    end
                end
                ST_SPLIT: begin
                    rem_next = rem_new;
                    quo_next = quo_new;
                    cnt_next = cnt_reg + 4'd1;
                    if (last_step) begin
                        row_next   = quo_new[5:0];
                        col_next   = rem_new[4:0];
                        state_next = ST_IDLE;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        part_reg <= part_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        div_reg  <= div_next;
    end

    assign info = {(state_reg != ST_IDLE), row_reg, col_reg};

endmodule

// ----- sv/wlan_ht_bit_interleaver.sv -----
// ----------------------------------------------------------------------------
// wlan_ht_bit_interleaver
// HT bit interleaver with frequency rotation for one spatial stream.
//
//   port group  dir  fields (lowest bit first)
//   s_*         in   tdata: data_bit | tlast: packet_end | tuser: cmd
//   m_*         out  tdata: out_bit | tlast: block_end | tuser: bit_valid, short_block
//   cfg_*       in   index 0..4: rows, columns, bits/subcarrier, rotation, stream
//
// One item per cycle while s_tready is high; a result is registered in the store
// read register, then in the output register. Blocks are double banked, so output
// runs one block behind input. A config write holds s_tready low while the divider
// works out the rotation start. Reset clears control state; the bit store is not
// cleared. A stall on m_ holds s_tready low once the pipe register is full.
// ----------------------------------------------------------------------------
module wlan_ht_bit_interleaver import htbi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [0] data_bit
    input  logic                 s_tlast,
    input  logic [0:0]           s_tuser,   // [0] cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [0] out_bit
    output logic                 m_tlast,
    output logic [1:0]           m_tuser,   // [0] bit_valid, [1] short_block
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // configuration
    logic [6:0] rows_cfg_reg;
    logic [5:0] cols_cfg_reg;
    logic [3:0] bpsc_cfg_reg;
    logic [5:0] rot_cfg_reg;
    logic [1:0] stream_cfg_reg;
    logic       cfg_hit;

    // interleaver state
    logic [DIV_W-1:0] wcount_reg, wcount_next;
    logic             wbank_reg, wbank_next;
    logic [DIV_W-1:0] rremain_reg, rremain_next;
    logic [5:0]       rrow_reg, rrow_next;
    logic [4:0]       rcol_reg, rcol_next;

    // pipe and output stages
    logic p_valid_reg, p_bitv_reg, p_bend_reg, p_short_reg;
    logic rd_data_reg;
    logic out_bit_reg, out_bitv_reg, out_bend_reg, out_short_reg;
    logic m_valid_reg;

    logic [STORE_AW-1:0] store_wr_addr, store_rd_addr;
    logic                store_wr_en, store_rd_en;
    logic                store [0:(1 << STORE_AW)-1];

    rot_info_t        rot;
    logic [5:0]       cols;
    logic [6:0]       rows;
    logic [DIV_W-1:0] block_len;
    logic             accept, out_free, rd_act, is_data, blk_done, short_now;
    logic [DIV_W-1:0] src_addr;
    logic [DIV_W-1:0] wc_inc;
    logic [5:0]       col_inc;
    logic [6:0]       row_inc;

    assign cols      = eff_cols(cols_cfg_reg);
    assign rows      = eff_rows(rows_cfg_reg);
    assign block_len = {5'd0, rows} * {6'd0, cols};

    assign cfg_hit = cfg_we && (cfg_index <= CFG_STREAM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg   <= 7'd4;
            cols_cfg_reg   <= 6'd13;
            bpsc_cfg_reg   <= 4'd1;
            rot_cfg_reg    <= 6'd11;
            stream_cfg_reg <= 2'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ROWS:   rows_cfg_reg   <= cfg_data[6:0];
                CFG_COLS:   cols_cfg_reg   <= cfg_data[5:0];
                CFG_BPSC:   bpsc_cfg_reg   <= cfg_data[3:0];
                CFG_ROT:    rot_cfg_reg    <= cfg_data[5:0];
                CFG_STREAM: stream_cfg_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    htbi_rotation u_rotation (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cfg_hit),
        .stream    (stream_cfg_reg),
        .rot_step  (rot_cfg_reg),
        .bpsc      (bpsc_cfg_reg),
        .block_len (block_len),
        .cols      (cols),
        .info      (rot)
    );

    // handshake
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !rot.busy && !cfg_we && (!p_valid_reg || out_free);
    assign accept   = s_tvalid && s_tready;

    assign rd_act    = (rremain_reg != '0);
    assign is_data   = (s_tuser[0] == CMD_DATA);
    assign wc_inc    = wcount_reg + DIV_W'(1);
    assign blk_done  = is_data && (wc_inc >= block_len);
    assign short_now = is_data && !blk_done && s_tlast;

    assign src_addr = ({7'd0, rcol_reg} * {5'd0, rows}) + {6'd0, rrow_reg};
    assign col_inc  = {1'b0, rcol_reg} + 6'd1;
    assign row_inc  = {1'b0, rrow_reg} + 7'd1;

    assign store_rd_en   = accept && rd_act;
    assign store_rd_addr = {~wbank_reg, src_addr[BLK_AW-1:0]};
    assign store_wr_en   = accept && is_data;
    assign store_wr_addr = {wbank_reg, wcount_reg[BLK_AW-1:0]};

    always_ff @(posedge aclk) begin
        if (store_wr_en) store[store_wr_addr] <= s_tdata[0];
        if (store_rd_en) rd_data_reg <= store[store_rd_addr];
    end

    always_comb begin
        wcount_next  = wcount_reg;
        wbank_next   = wbank_reg;
        rremain_next = rremain_reg;
        rrow_next    = rrow_reg;
        rcol_next    = rcol_reg;
        if (accept) begin
            if (rd_act) begin
                rremain_next = rremain_reg - DIV_W'(1);
                rcol_next    = col_inc[4:0];
                if (col_inc >= cols) begin
                    rcol_next = '0;
                    rrow_next = (row_inc >= rows) ? 6'd0 : row_inc[5:0];
                end
            end
            if (is_data) begin
                wcount_next = wc_inc;
                if (blk_done) begin
                    wcount_next  = '0;
                    wbank_next   = ~wbank_reg;
                    rremain_next = block_len;
                    rrow_next    = rot.start_row;
                    rcol_next    = rot.start_col;
                end else if (s_tlast) begin
                    wcount_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcount_reg  <= '0;
            wbank_reg   <= 1'b0;
            rremain_reg <= '0;
            rrow_reg    <= '0;
            rcol_reg    <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            wcount_reg  <= wcount_next;
            wbank_reg   <= wbank_next;
            rremain_reg <= rremain_next;
            rrow_reg    <= rrow_next;
            rcol_reg    <= rcol_next;
            if (accept) p_valid_reg <= rd_act || short_now;
            else if (out_free) p_valid_reg <= 1'b0;
            if (out_free) m_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_bitv_reg  <= rd_act;
            p_bend_reg  <= rd_act && (rremain_reg == DIV_W'(1));
            p_short_reg <= short_now;
        end
        if (out_free && p_valid_reg) begin
            out_bit_reg   <= p_bitv_reg && rd_data_reg;
            out_bitv_reg  <= p_bitv_reg;
            out_bend_reg  <= p_bend_reg;
            out_short_reg <= p_short_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_bit_reg};
    assign m_tlast  = out_bend_reg;
    assign m_tuser  = {out_short_reg, out_bitv_reg};

    ap_bank_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (store_rd_en && store_wr_en) |->
            (store_rd_addr[STORE_AW-1] != store_wr_addr[STORE_AW-1]))
        else $error("read and write hit the same bank");

    ap_busy_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        rot.busy |-> !s_tready)
        else $error("item taken while rotation is being computed");

    ap_swap_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && blk_done) |=> (rremain_reg == $past(block_len)) &&
            (wbank_reg != $past(wbank_reg)))
        else $error("block completion did not start the read");

    ap_no_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] || m_tuser[1]))
        else $error("empty result item");

    ap_last_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[0])
        else $error("block end on an item without a bit");

endmodule
